[hw/rtl/yee_field_cell_update_unit_macros.svh]
// Assertion macros used by the checker file of the cell update unit.
`ifndef YEE_FIELD_CELL_UPDATE_UNIT_MACROS_SVH
`define YEE_FIELD_CELL_UPDATE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define YFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("yfc assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define YFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yfc assertion failed");

`endif

[hw/rtl/yfc_pkg.sv]
// ----------------------------------------------------------------------------
// yfc_pkg
// Types and constants shared by the Yee cell update unit and its checker.
// ----------------------------------------------------------------------------
package yfc_pkg;

  // Transaction kinds carried on in_tuser.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  // Six field components: electric x,y,z then magnetic x,y,z.
  localparam int unsigned COMPONENTS = 6;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned STRETCH_W   = 31;
  localparam int unsigned COMPONENT_W = 3;
  localparam int unsigned MATERIAL_W  = 4;

  // Input tdata layout, lowest bit first.
  localparam int unsigned IN_TDATA_W = 296;
  localparam int unsigned OFS_COMP   = 0;
  localparam int unsigned OFS_MAT    = 3;
  localparam int unsigned OFS_OLD    = 7;
  localparam int unsigned OFS_FH     = 39;
  localparam int unsigned OFS_FL     = 71;
  localparam int unsigned OFS_FS     = 103;
  localparam int unsigned OFS_SH     = 134;
  localparam int unsigned OFS_SL     = 166;
  localparam int unsigned OFS_SS     = 198;
  localparam int unsigned OFS_LK     = 229;
  localparam int unsigned OFS_LC     = 261;

  localparam int unsigned OUT_TDATA_W = 32;

  // Coefficient pair as held in the table memory.
  typedef struct packed {
    logic signed [VALUE_W-1:0] keep;
    logic signed [VALUE_W-1:0] curl;
  } coef_t;

endpackage

[hw/rtl/yfc_ram.sv]
// ----------------------------------------------------------------------------
// yfc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module yfc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/yfc_div_pipe.sv]
// ----------------------------------------------------------------------------
// yfc_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// side payload that travels alongside each transaction.
// ----------------------------------------------------------------------------
module yfc_div_pipe #(
  parameter int unsigned MAG_W  = 48,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [MAG_W-1:0]                in_dividend,
  input  logic [yfc_pkg::STRETCH_W-1:0]   in_divisor,
  input  logic [SIDE_W-1:0]               in_side,
  output logic                            out_valid,
  output logic [MAG_W-1:0]                out_quotient,
  output logic [SIDE_W-1:0]               out_side
);

  localparam int unsigned DV_W = yfc_pkg::STRETCH_W;

  // Per stage: dividend bits shift out at the top, quotient bits in at the bottom.
  logic [MAG_W-1:0]  dq_r   [MAG_W];
  logic [DV_W-1:0]   rem_r  [MAG_W];
  logic [DV_W-1:0]   dvs_r  [MAG_W];
  logic [SIDE_W-1:0] side_r [MAG_W];
  logic              vld_r  [MAG_W];

  for (genvar s = 0; s < MAG_W; s++) begin : g_stage
    logic [MAG_W-1:0]  dq_src;
    logic [DV_W-1:0]   rem_src;
    logic [DV_W-1:0]   dvs_src;
    logic [SIDE_W-1:0] side_src;
    logic              vld_src;
    logic [DV_W:0]     trial;
    logic [DV_W:0]     trial_sub;
    logic              fits;
    logic [DV_W-1:0]   rem_nxt;
    logic [MAG_W-1:0]  dq_nxt;

    if (s == 0) begin : g_first
      assign dq_src   = in_dividend;
      assign rem_src  = '0;
      assign dvs_src  = in_divisor;
      assign side_src = in_side;
      assign vld_src  = in_valid;
    end else begin : g_next
      assign dq_src   = dq_r[s-1];
      assign rem_src  = rem_r[s-1];
      assign dvs_src  = dvs_r[s-1];
      assign side_src = side_r[s-1];
      assign vld_src  = vld_r[s-1];
    end

    // One trial subtraction decides one quotient bit.
    always_comb begin
      trial     = {rem_src, dq_src[MAG_W-1]};
      trial_sub = trial - {1'b0, dvs_src};
      fits      = (trial >= {1'b0, dvs_src});
      rem_nxt   = fits ? trial_sub[DV_W-1:0] : trial[DV_W-1:0];
      dq_nxt    = {dq_src[MAG_W-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[s]   <= dq_nxt;
        rem_r[s]  <= rem_nxt;
        dvs_r[s]  <= dvs_src;
        side_r[s] <= side_src;
      end
    end
  end

  assign out_valid    = vld_r[MAG_W-1];
  assign out_quotient = dq_r[MAG_W-1];
  assign out_side     = side_r[MAG_W-1];

endmodule

[hw/rtl/yee_field_cell_update_unit.sv]
// Throughput: one transaction per cycle while the output is not stalled; the
// two pipelined dividers, one quotient bit per stage, set the depth. Loads and
// invalid items give no result.
// Reset clears all valid flags; the coefficient table is undefined until loaded.
// ----------------------------------------------------------------------------
// yee_field_cell_update_unit
// Yee FDTD cell update: new = keep*old + curl*(d1/s1 + d2/s2), Q16.16, saturated.
// ----------------------------------------------------------------------------
module yee_field_cell_update_unit #(
  parameter int unsigned MATERIALS     = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // component, material, old_value, first_high, first_low, first_stretch,
  // second_high, second_low, second_stretch, load_keep, load_curl, zero pad
  input  logic [yfc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // action
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // new_value
  output logic [yfc_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int unsigned VW      = yfc_pkg::VALUE_W;
  localparam int unsigned SW      = yfc_pkg::STRETCH_W;
  localparam int unsigned DEPTH   = yfc_pkg::COMPONENTS * MATERIALS;
  localparam int unsigned SLOT_W  = $clog2(DEPTH);
  localparam int unsigned MAG_W   = VW + FRACTION_BITS;
  localparam int unsigned SUM_W   = MAG_W + 2;
  localparam int unsigned PROD_W  = 2 * VW;
  localparam int unsigned SIDE1_W = 3 * VW + 3;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-VW){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W-VW){1'b1}}, 32'h8000_0000};
  localparam logic signed [PROD_W:0]  TOT_MAX = {{(PROD_W+1-VW){1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [PROD_W:0]  TOT_MIN = {{(PROD_W+1-VW){1'b1}}, 32'h8000_0000};

  // Field extraction.
  logic [yfc_pkg::COMPONENT_W-1:0] in_comp;
  logic [yfc_pkg::MATERIAL_W-1:0]  in_mat;
  logic signed [VW-1:0]            in_old, in_fh, in_fl, in_sh, in_sl;
  logic [SW-1:0]                   in_fs, in_ss;
  yfc_pkg::coef_t                  in_coef;

  assign in_comp      = in_tdata[yfc_pkg::OFS_COMP +: yfc_pkg::COMPONENT_W];
  assign in_mat       = in_tdata[yfc_pkg::OFS_MAT  +: yfc_pkg::MATERIAL_W];
  assign in_old       = in_tdata[yfc_pkg::OFS_OLD  +: VW];
  assign in_fh        = in_tdata[yfc_pkg::OFS_FH   +: VW];
  assign in_fl        = in_tdata[yfc_pkg::OFS_FL   +: VW];
  assign in_fs        = in_tdata[yfc_pkg::OFS_FS   +: SW];
  assign in_sh        = in_tdata[yfc_pkg::OFS_SH   +: VW];
  assign in_sl        = in_tdata[yfc_pkg::OFS_SL   +: VW];
  assign in_ss        = in_tdata[yfc_pkg::OFS_SS   +: SW];
  assign in_coef.keep = in_tdata[yfc_pkg::OFS_LK   +: VW];
  assign in_coef.curl = in_tdata[yfc_pkg::OFS_LC   +: VW];

  // Whole pipeline advances unless the output register is full and stalled.
  logic en;
  logic accept;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  // Table slot and its validity.
  logic [SLOT_W-1:0] slot;
  logic              slot_ok;
  assign slot    = SLOT_W'(SLOT_W'(in_comp) * SLOT_W'(MATERIALS)) + SLOT_W'(in_mat);
  assign slot_ok = (in_comp < 3'(yfc_pkg::COMPONENTS)) && (9'(in_mat) < 9'(MATERIALS));

  // Coefficient table: loads write; updates read, registered alongside stage A.
  yfc_pkg::coef_t coef_rd;
  logic           tbl_we, tbl_re;
  assign tbl_we = accept && (in_tuser == yfc_pkg::ACT_LOAD) && slot_ok;
  assign tbl_re = accept && (in_tuser == yfc_pkg::ACT_UPDATE) && slot_ok;

  yfc_ram #(.WIDTH($bits(yfc_pkg::coef_t)), .DEPTH(DEPTH)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (slot),
    .wdata (in_coef),
    .re    (tbl_re),
    .raddr (slot),
    .rdata (coef_rd)
  );

  // Differences formed at 33 bits; magnitudes fit in 32.
  logic signed [VW:0] d1, d2;
  logic [VW:0]        d1_abs, d2_abs;
  assign d1     = {in_fh[VW-1], in_fh} - {in_fl[VW-1], in_fl};
  assign d2     = {in_sh[VW-1], in_sh} - {in_sl[VW-1], in_sl};
  assign d1_abs = d1[VW] ? -d1 : d1;
  assign d2_abs = d2[VW] ? -d2 : d2;

  // Stage A: operands registered.
  logic                 a_valid_r;
  logic signed [VW-1:0] a_old_r;
  logic [VW-1:0]        a_mag1_r, a_mag2_r;
  logic [SW-1:0]        a_s1_r, a_s2_r;
  logic                 a_neg1_r, a_neg2_r, a_nz1_r, a_nz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= tbl_re;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_old_r  <= in_old;
      a_mag1_r <= d1_abs[VW-1:0];
      a_mag2_r <= d2_abs[VW-1:0];
      a_s1_r   <= in_fs;
      a_s2_r   <= in_ss;
      a_neg1_r <= d1[VW];
      a_neg2_r <= d2[VW];
      a_nz1_r  <= (d1 != '0);
      a_nz2_r  <= (d2 != '0);
    end
  end

  // Two dividers; the first carries the rest of the transaction.
  logic               q1_valid, q2_valid;
  logic [MAG_W-1:0]   q1_mag, q2_mag;
  logic [SIDE1_W-1:0] side1_in, side1_out;
  logic [2:0]         side2_out;

  assign side1_in = {a_old_r, coef_rd.keep, coef_rd.curl, a_neg1_r, a_nz1_r, (a_s1_r == '0)};

  yfc_div_pipe #(.MAG_W(MAG_W), .SIDE_W(SIDE1_W)) u_div1 (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (a_valid_r),
    .in_dividend  ({a_mag1_r, {FRACTION_BITS{1'b0}}}),
    .in_divisor   (a_s1_r),
    .in_side      (side1_in),
    .out_valid    (q1_valid),
    .out_quotient (q1_mag),
    .out_side     (side1_out)
  );

  yfc_div_pipe #(.MAG_W(MAG_W), .SIDE_W(3)) u_div2 (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (a_valid_r),
    .in_dividend  ({a_mag2_r, {FRACTION_BITS{1'b0}}}),
    .in_divisor   (a_s2_r),
    .in_side      ({a_neg2_r, a_nz2_r, (a_s2_r == '0)}),
    .out_valid    (q2_valid),
    .out_quotient (q2_mag),
    .out_side     (side2_out)
  );

  // Signed quotients, zero-stretch handling, saturated sum.
  logic signed [VW-1:0]  x_old, x_keep, x_curl;
  logic                  x_neg1, x_nz1, x_zs1, x_neg2, x_nz2, x_zs2;
  logic signed [MAG_W:0] q1_s, q2_s;
  logic signed [SUM_W-1:0] qsum;
  logic signed [VW-1:0]  qsum_sat;

  assign {x_old, x_keep, x_curl, x_neg1, x_nz1, x_zs1} = side1_out;
  assign {x_neg2, x_nz2, x_zs2} = side2_out;

  always_comb begin
    q1_s = x_neg1 ? -$signed({1'b0, q1_mag}) : $signed({1'b0, q1_mag});
    q2_s = x_neg2 ? -$signed({1'b0, q2_mag}) : $signed({1'b0, q2_mag});
    if (x_zs1) begin
      q1_s = !x_nz1 ? '0 : (x_neg1 ? SUM_MIN[MAG_W:0] : SUM_MAX[MAG_W:0]);
    end
    if (x_zs2) begin
      q2_s = !x_nz2 ? '0 : (x_neg2 ? SUM_MIN[MAG_W:0] : SUM_MAX[MAG_W:0]);
    end
    qsum = SUM_W'(q1_s) + SUM_W'(q2_s);
    if (qsum > SUM_MAX) begin
      qsum_sat = SUM_MAX[VW-1:0];
    end else if (qsum < SUM_MIN) begin
      qsum_sat = SUM_MIN[VW-1:0];
    end else begin
      qsum_sat = qsum[VW-1:0];
    end
  end

  // Stage S: curl sum registered.
  logic                 s_valid_r;
  logic signed [VW-1:0] s_old_r, s_keep_r, s_curl_r, s_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (en) begin
      s_valid_r <= q1_valid && q2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_old_r  <= x_old;
      s_keep_r <= x_keep;
      s_curl_r <= x_curl;
      s_sum_r  <= qsum_sat;
    end
  end

  // Stage M: the two products.
  logic                     m_valid_r;
  logic signed [PROD_W-1:0] m_kept_r, m_curled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_kept_r   <= s_keep_r * s_old_r;
      m_curled_r <= s_curl_r * s_sum_r;
    end
  end

  // Floor shift, add and saturate into the output register.
  logic signed [PROD_W-1:0] kept_sh, curled_sh;
  logic signed [PROD_W:0]   total;
  logic signed [VW-1:0]     total_sat;

  always_comb begin
    kept_sh   = m_kept_r >>> FRACTION_BITS;
    curled_sh = m_curled_r >>> FRACTION_BITS;
    total     = {kept_sh[PROD_W-1], kept_sh} + {curled_sh[PROD_W-1], curled_sh};
    if (total > TOT_MAX) begin
      total_sat = TOT_MAX[VW-1:0];
    end else if (total < TOT_MIN) begin
      total_sat = TOT_MIN[VW-1:0];
    end else begin
      total_sat = total[VW-1:0];
    end
  end

  logic [VW-1:0]   out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= total_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/yfc_checker.sv]
// ----------------------------------------------------------------------------
// yfc_checker
// Port-level checks on the result channel and the input back-pressure.
// ----------------------------------------------------------------------------
`include "yee_field_cell_update_unit_macros.svh"

module yfc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [yfc_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result stays offered with the same value.
  `YFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `YFC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // The input side is free whenever the output register is empty or drains.
  `YFC_ASSERT_SAME(a_in_free, clk, rst_n, !out_tvalid || out_tready, in_tready)

  // A stalled output holds back the input side.
  `YFC_ASSERT_SAME(a_in_block, clk, rst_n, out_tvalid && !out_tready, !in_tready)

endmodule

bind yee_field_cell_update_unit yfc_checker u_yfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
